/* sv/cidal_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the card id allowlist engine
// no dependencies

package cidal_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_CARD  = 2'd0,
    CMD_MODE  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    STS_AUTH      = 3'd0,
    STS_UNKNOWN   = 3'd1,
    STS_ADDED     = 3'd2,
    STS_DUP       = 3'd3,
    STS_FULL      = 3'd4,
    STS_TO_RECORD = 3'd5,
    STS_TO_READ   = 3'd6,
    STS_ERASED    = 3'd7
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  localparam int unsigned CARD_ID_W = 32;
  localparam int unsigned COUNT_OUT_W = 7;

endpackage

/* sv/cidal_id_mem.sv */
`timescale 1ns / 1ps
// identifier table: one write port, one registered read port
// no dependencies

module cidal_id_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] id_mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      id_mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= id_mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/cidal_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: command decode, linear table scan, append and result register
// depends on cidal_pkg

module cidal_ctrl
  import cidal_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ID_W   = 32,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned CNT_W  = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [ID_W-1:0]   in_id,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [ID_W-1:0]   mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [ID_W-1:0]   mem_rdata,
  output logic              out_strobe,
  output logic [2:0]        out_status,
  output logic              out_grant,
  output logic              mode_out,
  output logic [CNT_W-1:0]  count_out
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             dvld_r, dvld_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             strobe_r, strobe_nxt;
  status_t          status_r, status_nxt;
  logic             grant_r, grant_nxt;

  logic             hit;
  logic             issue;
  logic             scan_done;

  // compare the entry read last cycle, and keep issuing reads below the count
  assign hit       = dvld_r && (mem_rdata == id_r);
  assign issue     = (ptr_r < count_r) && !hit;
  assign scan_done = hit || ((ptr_r == count_r) && !dvld_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      mode_r   <= 1'b0;
      dvld_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      dvld_r   <= dvld_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    ptr_nxt    = ptr_r;
    dvld_nxt   = dvld_r;
    id_nxt     = id_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    mem_we     = 1'b0;
    mem_waddr  = count_r[ADDR_W-1:0];
    mem_wdata  = id_r;
    mem_raddr  = ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt = in_id;
          case (cmd_t'(in_command))
            CMD_CARD: begin
              state_nxt = S_SCAN;
              ptr_nxt   = '0;
              dvld_nxt  = 1'b0;
            end
            CMD_MODE: begin
              mode_nxt   = ~mode_r;
              strobe_nxt = 1'b1;
              status_nxt = mode_r ? STS_TO_READ : STS_TO_RECORD;
              grant_nxt  = 1'b0;
            end
            CMD_ERASE: begin
              count_nxt  = '0;
              mode_nxt   = 1'b0;
              strobe_nxt = 1'b1;
              status_nxt = STS_ERASED;
              grant_nxt  = 1'b0;
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = STS_UNKNOWN;
              grant_nxt  = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        ptr_nxt  = issue ? ptr_r + 1'b1 : ptr_r;
        dvld_nxt = issue;
        if (scan_done) begin
          state_nxt  = S_IDLE;
          dvld_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          grant_nxt  = 1'b0;
          if (!mode_r) begin
            status_nxt = hit ? STS_AUTH : STS_UNKNOWN;
            grant_nxt  = hit;
          end else if (hit) begin
            status_nxt = STS_DUP;
          end else if (count_r < FULL_COUNT) begin
            // append at the fill position
            mem_we     = 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = STS_ADDED;
          end else begin
            status_nxt = STS_FULL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_grant  = grant_r;
  assign mode_out   = mode_r;
  assign count_out  = count_r;

endmodule

/* sv/card_id_allowlist_engine_unit.sv */
`timescale 1ns / 1ps
// top level of the card id allowlist engine
// depends on cidal_pkg, cidal_ctrl, cidal_id_mem

// An item is taken when start is high and busy is low. Mode, erase and spare
// items do not scan: the result strobe rises the cycle after the item is
// taken. A card item scans the stored identifiers through the table memory
// one entry per cycle. On a nonempty table it compares each stored entry as
// its registered read returns, then registers the result; on an empty table
// it registers the result at once. A match ends the scan early. An append is
// written at the same edge the result is registered. out_strobe marks each
// result for exactly one cycle and there is no back pressure, so the receiver
// must take every result as it appears. out_record_mode and out_entry_count
// show state after the item (count is modulo 128). Only the low ID_BYTES
// bytes of in_card_id are stored and compared, all 32 bits when ID_BYTES is
// four or more.

module card_id_allowlist_engine_unit
  import cidal_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BYTES    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_card_id,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_grant,
  output logic        out_record_mode,
  output logic [6:0]  out_entry_count
);

  localparam int unsigned ID_W   = (ID_BYTES >= 4) ? CARD_ID_W : ID_BYTES * 8;
  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ID_W-1:0]   mem_rdata;
  logic [CNT_W-1:0]  count;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  // sequencer
  cidal_ctrl #(
    .DEPTH  (TABLE_DEPTH),
    .ID_W   (ID_W),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_id      (in_card_id[ID_W-1:0]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_grant  (out_grant),
    .mode_out   (out_record_mode),
    .count_out  (count)
  );

  // identifier table
  cidal_id_mem #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (ID_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // count shown modulo 128
  assign count_ext       = {{COUNT_OUT_W{1'b0}}, count};
  assign out_entry_count = count_ext[COUNT_OUT_W-1:0];

endmodule
